[src/dca_pkg.sv]
`default_nettype none

package dca_pkg;

	localparam int unsigned MAX_LENGTH   = 65535;
	localparam int unsigned HEADER_BYTES = 4;
	localparam int unsigned FIELD_LEN_MAX = 65536;

	localparam int unsigned LEN_LIMIT =
		(MAX_LENGTH + 1 > FIELD_LEN_MAX) ? FIELD_LEN_MAX : MAX_LENGTH + 1;
	localparam logic [16:0] TOTAL_LIMIT = 17'(LEN_LIMIT + HEADER_BYTES);
	localparam logic [16:0] HDR_LEN     = 17'(HEADER_BYTES);

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_ADMITTED  = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_MISMATCH  = 2'd3
	} dca_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} dca_in_t;

	typedef struct packed {
		dca_status_t status;
		logic [31:0] wire_checksum;
		logic [31:0] computed_checksum;
		logic [16:0] payload_length;
	} dca_out_t;

endpackage

`default_nettype wire

[src/datagram_checksum_admission.sv]
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------
// in       | sink      | in_valid/in_stall  | in_data (byte, last flag)
// out      | source    | out_valid/out_stall| out_data (status, sums, len)
// cfg      | sink      | cfg_we             | cfg_wdata (payload capacity)
//
// One byte is taken every cycle while in_stall is low; a byte goes through an
// input register and the result of a final byte lands in the output register.
// Each 32-bit payload word costs one rotate-and-add fold; a final byte adds one compare.
// Reset clears the frame state and sets the capacity to 65535.
// A final byte waits in the input register only while the output register
// holds an untaken result; other bytes never wait.

module datagram_checksum_admission
	import dca_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire dca_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output dca_out_t         out_data,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic        valid_s1;
	dca_in_t     in_s1;
	logic [15:0] cap_q;
	logic [31:0] sum_q;
	logic [31:0] wire_q;
	logic [23:0] pend_q;
	logic [1:0]  lane_q;
	logic [16:0] cnt_q;
	logic        out_valid_q;
	dca_out_t    out_q;

	logic        out_free;
	logic        move_s1;
	logic        hdr;
	logic [31:0] word;
	logic [31:0] folded;
	logic [31:0] wire_nx;
	logic [31:0] sum_nx;
	logic [23:0] pend_nx;
	logic [1:0]  lane_nx;
	logic [16:0] cnt_nx;
	logic [16:0] plen;
	dca_out_t    res;

	assign out_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && (!in_s1.last || out_free);
	assign in_stall = valid_s1 && in_s1.last && !out_free;

	always_comb begin
		hdr     = (cnt_q < HDR_LEN);
		word    = {8'd0, pend_q} | (32'(in_s1.data_byte) << {lane_q, 3'b000});
		folded  = {sum_q[30:0], sum_q[31]} + word;
		wire_nx = wire_q;
		sum_nx  = sum_q;
		pend_nx = pend_q;
		lane_nx = lane_q;
		if (hdr) begin
			wire_nx = wire_q | (32'(in_s1.data_byte) << {cnt_q[1:0], 3'b000});
		end else begin
			if (lane_q == 2'd3) begin
				sum_nx  = folded;
				pend_nx = '0;
			end else begin
				pend_nx = word[23:0];
			end
			lane_nx = lane_q + 2'd1;
		end
		cnt_nx = (cnt_q < TOTAL_LIMIT) ? cnt_q + 17'd1 : cnt_q;
		plen   = cnt_nx - HDR_LEN;

		res.wire_checksum     = wire_nx;
		res.computed_checksum = folded;
		res.payload_length    = plen;
		if (cnt_nx <= HDR_LEN) begin
			res.status            = ST_TOO_SHORT;
			res.computed_checksum = '0;
			res.payload_length    = '0;
		end else if (plen > {1'b0, cap_q}) begin
			res.status = ST_TOO_LARGE;
		end else if (wire_nx != folded) begin
			res.status = ST_MISMATCH;
		end else begin
			res.status = ST_ADMITTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			wire_q <= '0;
			pend_q <= '0;
			lane_q <= '0;
			cnt_q  <= '0;
		end else if (move_s1) begin
			if (in_s1.last) begin
				sum_q  <= '0;
				wire_q <= '0;
				pend_q <= '0;
				lane_q <= '0;
				cnt_q  <= '0;
			end else begin
				sum_q  <= sum_nx;
				wire_q <= wire_nx;
				pend_q <= pend_nx;
				lane_q <= lane_nx;
				cnt_q  <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1 && in_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && in_s1.last) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[src/dca_checker.sv]
`default_nettype none

module dca_checker
	import dca_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire dca_out_t out_data
);

	// A stalled result must be held until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_TOO_SHORT |->
		out_data.computed_checksum == 32'd0 && out_data.payload_length == 17'd0)
		else $error("too short result carries a checksum or length");

	a_admit_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_ADMITTED |->
		out_data.wire_checksum == out_data.computed_checksum &&
		out_data.payload_length != 17'd0)
		else $error("admitted datagram with bad checksum or empty payload");

	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_MISMATCH |->
		out_data.wire_checksum != out_data.computed_checksum)
		else $error("mismatch reported on equal checksums");

endmodule

bind datagram_checksum_admission dca_checker u_dca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
